@@ sv/sfc_pkg.sv @@
// Shared types, constants and key functions for the curve sort.
package sfc_pkg;

   localparam int MaxTrisDefault = 64;
   localparam int FractionBitsDefault = 12;
   localparam int CoordWidth = 32;
   localparam int SumWidth = CoordWidth + 2;
   localparam int KeyWidth = 48;
   localparam int IndexWidth = 6;
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic signed [CoordWidth-1:0] v0x;
      logic signed [CoordWidth-1:0] v0y;
      logic signed [CoordWidth-1:0] v0z;
      logic signed [SumWidth-1:0]   sx;
      logic signed [SumWidth-1:0]   sy;
      logic signed [SumWidth-1:0]   sz;
      logic                         last;
   } tri_entry_type;

   typedef struct packed {
      logic [IndexWidth-1:0] index;
      logic [KeyWidth-1:0]   key_high;
      logic [KeyWidth-1:0]   key_low;
      logic                  run_end;
   } result_type;

   function automatic logic [KeyWidth-1:0] spread3(input logic [15:0] v);
      logic [KeyWidth-1:0] r;
      r = KeyWidth'(v);
      r = (r | (r << 16)) & 48'h0000ff0000ff;
      r = (r | (r << 8)) & 48'h00f00f00f00f;
      r = (r | (r << 4)) & 48'h0c30c30c30c3;
      r = (r | (r << 2)) & 48'h249249249249;
      return r;
   endfunction

   function automatic logic [KeyWidth-1:0] curve_code(input logic [15:0] x,
      input logic [15:0] y, input logic [15:0] z, input logic mode);
      logic [KeyWidth-1:0] c;
      c = spread3(x) | (spread3(y) << 1) | (spread3(z) << 2);
      if (!mode) begin
         c = c ^ (c >> 32);
         c = c ^ (c >> 16);
         c = c ^ (c >> 8);
         c = c ^ (c >> 4);
         c = c ^ (c >> 2);
         c = c ^ (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ sv/sfc_if.sv @@
// Valid/ready channel interfaces for the curve sort.
interface sfc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sfc_pkg::CoordWidth-1:0] v0_x, v0_y, v0_z;
   logic signed [sfc_pkg::CoordWidth-1:0] v1_x, v1_y, v1_z;
   logic signed [sfc_pkg::CoordWidth-1:0] v2_x, v2_y, v2_z;
   logic                                 final_triangle;
   modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, final_triangle, input ready);
   modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, final_triangle, output ready);
   modport monitor(input valid, ready, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, final_triangle);
endinterface

interface sfc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sfc_pkg::IndexWidth-1:0]     triangle_index;
   logic [sfc_pkg::KeyWidth-1:0]       key_high;
   logic [sfc_pkg::KeyWidth-1:0]       key_low;
   logic                               run_end;
   modport source(output valid, triangle_index, key_high, key_low, run_end,
                  input ready);
   modport sink(input valid, triangle_index, key_high, key_low, run_end,
                output ready);
   modport monitor(input valid, ready, triangle_index, key_high, key_low, run_end);
endinterface

interface sfc_csr_if;
   logic valid;
   logic ready;
   logic curve_mode;
   modport source(output valid, curve_mode, input ready);
   modport sink(input valid, curve_mode, output ready);
   modport monitor(input valid, ready, curve_mode);
endinterface

@@ sv/space_filling_curve_sort.sv @@
// Top level of the space-filling-curve triangle sort.
//  channel | prefix | direction | moves
//  req     | req_   | in        | one triangle request (three vertices, final flag)
//  rsp     | rsp_   | out       | one sorted index with its two keys
//  csr     | csr_   | in        | curve_mode write
// Loading pops, divides and stores each stored request, and only pops a dropped
// request; the two-entry queue lets the front accept meanwhile.
// Keying reads a centroid, then writes its keys; an insertion-sort compare step
// fetches the prior index, then its keys, then decides; results wait on rsp_ready.
// csr_ready is high only while the back end is idle and the queue is empty.
// Reset clears the queue, counters, minimum and curve_mode; no clearing pass.
module space_filling_curve_sort #(
   parameter int MaxTris = sfc_pkg::MaxTrisDefault
) (
   input logic     clock,
   input logic     reset,
   sfc_req_if.sink req,
   sfc_rsp_if.source rsp,
   sfc_csr_if.sink csr
);
   import sfc_pkg::*;

   tri_entry_type q_data;
   logic q_valid, q_pop, busy;
   logic curve_mode_ff;

   // Take configuration only when nothing is in flight.
   assign csr.ready = !busy && !q_valid;
   always_ff @(posedge clock) begin
      if (reset) begin
         curve_mode_ff <= 1'b0;
      end else if (csr.valid && csr.ready) begin
         curve_mode_ff <= csr.curve_mode;
      end
   end

   sfc_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
   );

   sfc_back #(.MaxTris(MaxTris)) u_back (
      .clock(clock), .reset(reset), .curve_mode(curve_mode_ff),
      .q_data(q_data),
      .q_valid(q_valid), .q_pop(q_pop), .busy(busy), .rsp(rsp)
   );
endmodule

@@ sv/sfc_front.sv @@
// Front end: sum the three vertices of each request and queue it.
module sfc_front (
   input  logic                   clock,
   input  logic                   reset,
   sfc_req_if.sink                req,
   output sfc_pkg::tri_entry_type q_data,
   output logic                   q_valid,
   input  logic                   q_pop
);
   import sfc_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);

   tri_entry_type               mem_ff [QueueDepth];
   logic [PtrWidth-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrWidth:0]           cnt_ff, cnt_in;
   tri_entry_type               ent;
   logic                        push;

   // Keep the first vertex for the minimum seed; add the vertices per axis.
   always_comb begin
      ent.v0x = req.v0_x; ent.v0y = req.v0_y; ent.v0z = req.v0_z;
      ent.sx = SumWidth'(req.v0_x) + SumWidth'(req.v1_x) + SumWidth'(req.v2_x);
      ent.sy = SumWidth'(req.v0_y) + SumWidth'(req.v1_y) + SumWidth'(req.v2_y);
      ent.sz = SumWidth'(req.v0_z) + SumWidth'(req.v1_z) + SumWidth'(req.v2_z);
      ent.last = req.final_triangle;
   end

   assign req.ready = (cnt_ff != (PtrWidth+1)'(QueueDepth));
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != '0);
   assign q_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= ent;
      end
   end
endmodule

@@ sv/sfc_back.sv @@
// Back end: centroids, minimum, key build, insertion sort and emission.
module sfc_back #(
   parameter int MaxTris = sfc_pkg::MaxTrisDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   curve_mode,
   input  sfc_pkg::tri_entry_type q_data,
   input  logic                   q_valid,
   output logic                   q_pop,
   output logic                   busy,
   sfc_rsp_if.source              rsp
);
   import sfc_pkg::*;

   localparam int AW = $clog2(MaxTris);
   localparam int CW = $clog2(MaxTris + 1);
   localparam logic [3:0] S_LOAD = 4'd0, S_DIV = 4'd1, S_STORE = 4'd2,
      S_KRD = 4'd3, S_KEY = 4'd4, S_IRD = 4'd5, S_ICMP = 4'd6,
      S_ORD = 4'd7, S_EMIT = 4'd8, S_OUT = 4'd9;

   logic [3:0] st_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic last_ff;
   logic signed [CoordWidth-1:0] minx_ff, miny_ff, minz_ff;
   logic signed [SumWidth-1:0] sumx_ff, sumy_ff, sumz_ff;
   logic signed [CoordWidth-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [CoordWidth-1:0] qdx_ff, qdy_ff, qdz_ff;

   logic signed [CoordWidth-1:0] cxm [MaxTris];
   logic signed [CoordWidth-1:0] cym [MaxTris];
   logic signed [CoordWidth-1:0] czm [MaxTris];
   logic [KeyWidth-1:0] hkm [MaxTris];
   logic [KeyWidth-1:0] lkm [MaxTris];
   logic [AW-1:0] ordm [MaxTris];

   logic signed [CoordWidth-1:0] crx_ff, cry_ff, crz_ff;
   logic [KeyWidth-1:0] curh_ff, curl_ff, ph_ff, pl_ff;
   logic [AW-1:0] prev_ff;
   logic [AW-1:0] oidx_ff;
   logic [2:0] ph2_ff;

   // Truncating divide by 3 of a 34-bit signed sum: magnitude times 2^34/3.
   function automatic logic signed [CoordWidth-1:0] div3(
      input logic signed [SumWidth-1:0] s);
      logic [SumWidth-1:0] m;
      logic [2*CoordWidth+2:0] p;
      logic [CoordWidth-1:0] q;
      m = s[SumWidth-1] ? -s : s;
      p = (2*CoordWidth+3)'(m) * (2*CoordWidth+3)'(33'h155555556);
      q = p[CoordWidth+33:34];
      return s[SumWidth-1] ? -q : q;
   endfunction

   assign busy = (st_ff != S_LOAD);
   assign q_pop = (st_ff == S_LOAD) && q_valid;

   logic signed [CoordWidth-1:0] dx, dy, dz;
   assign dx = div3(sumx_ff);
   assign dy = div3(sumy_ff);
   assign dz = div3(sumz_ff);

   // Seed the minimum from the first vertex of the first triangle of a set.
   logic signed [CoordWidth-1:0] bx, by, bz;
   assign bx = (cnt_ff == '0) ? qx_ff : minx_ff;
   assign by = (cnt_ff == '0) ? qy_ff : miny_ff;
   assign bz = (cnt_ff == '0) ? qz_ff : minz_ff;

   logic [CoordWidth-1:0] ox, oy, oz;
   assign ox = crx_ff - minx_ff;
   assign oy = cry_ff - miny_ff;
   assign oz = crz_ff - minz_ff;

   logic after;
   assign after = (ph_ff > curh_ff) || (ph_ff == curh_ff && pl_ff > curl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; cnt_ff <= '0; rsp.valid <= 1'b0;
         minx_ff <= '0; miny_ff <= '0; minz_ff <= '0;
         i_ff <= '0; j_ff <= '0; last_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            S_LOAD: if (q_valid) begin
               sumx_ff <= q_data.sx; sumy_ff <= q_data.sy; sumz_ff <= q_data.sz;
               qx_ff <= q_data.v0x; qy_ff <= q_data.v0y; qz_ff <= q_data.v0z;
               last_ff <= q_data.last;
               st_ff <= (cnt_ff == CW'(MaxTris)) ?
                        (q_data.last ? S_KRD : S_LOAD) : S_DIV;
               i_ff <= '0;
            end
            S_DIV: begin
               qdx_ff <= dx; qdy_ff <= dy; qdz_ff <= dz;
               st_ff <= S_STORE;
            end
            S_STORE: begin
               cxm[cnt_ff[AW-1:0]] <= qdx_ff;
               cym[cnt_ff[AW-1:0]] <= qdy_ff;
               czm[cnt_ff[AW-1:0]] <= qdz_ff;
               minx_ff <= (qdx_ff < bx) ? qdx_ff : bx;
               miny_ff <= (qdy_ff < by) ? qdy_ff : by;
               minz_ff <= (qdz_ff < bz) ? qdz_ff : bz;
               cnt_ff <= cnt_ff + 1'b1;
               st_ff <= last_ff ? S_KRD : S_LOAD;
            end
            S_KRD: begin
               crx_ff <= cxm[i_ff[AW-1:0]];
               cry_ff <= cym[i_ff[AW-1:0]];
               crz_ff <= czm[i_ff[AW-1:0]];
               st_ff <= S_KEY;
            end
            S_KEY: begin
               hkm[i_ff[AW-1:0]] <= curve_code(ox[31:16], oy[31:16], oz[31:16],
                                               curve_mode);
               lkm[i_ff[AW-1:0]] <= curve_code(ox[15:0], oy[15:0], oz[15:0],
                                               curve_mode);
               if (i_ff + 1'b1 == cnt_ff) begin
                  i_ff <= '0; st_ff <= S_IRD;
               end else begin
                  i_ff <= i_ff + 1'b1; st_ff <= S_KRD;
               end
            end
            S_IRD: begin
               curh_ff <= hkm[i_ff[AW-1:0]];
               curl_ff <= lkm[i_ff[AW-1:0]];
               j_ff <= i_ff;
               ph2_ff <= 3'd0;
               st_ff <= S_ICMP;
            end
            S_ICMP: begin
               // fetch prev index, then its keys, then decide
               unique case (ph2_ff)
                  3'd0: begin
                     if (j_ff == '0) begin
                        ordm[0] <= i_ff[AW-1:0]; st_ff <= S_ORD;
                     end else begin
                        prev_ff <= ordm[j_ff[AW-1:0] - 1'b1]; ph2_ff <= 3'd1;
                     end
                  end
                  3'd1: begin
                     ph_ff <= hkm[prev_ff]; pl_ff <= lkm[prev_ff]; ph2_ff <= 3'd2;
                  end
                  default: begin
                     if (after) begin
                        ordm[j_ff[AW-1:0]] <= prev_ff;
                        j_ff <= j_ff - 1'b1; ph2_ff <= 3'd0;
                     end else begin
                        ordm[j_ff[AW-1:0]] <= i_ff[AW-1:0]; st_ff <= S_ORD;
                     end
                  end
               endcase
            end
            S_ORD: begin
               if (i_ff + 1'b1 == cnt_ff) begin
                  i_ff <= '0; st_ff <= (cnt_ff == '0) ? S_LOAD : S_EMIT;
               end else begin
                  i_ff <= i_ff + 1'b1; st_ff <= S_IRD;
               end
            end
            S_EMIT: begin
               oidx_ff <= ordm[i_ff[AW-1:0]];
               st_ff <= S_OUT;
               ph2_ff <= 3'd0;
            end
            S_OUT: begin
               if (ph2_ff == 3'd0) begin
                  rsp.key_high <= hkm[oidx_ff];
                  rsp.key_low <= lkm[oidx_ff];
                  rsp.triangle_index <= IndexWidth'(oidx_ff);
                  rsp.run_end <= (i_ff + 1'b1 == cnt_ff);
                  rsp.valid <= 1'b1;
                  ph2_ff <= 3'd1;
               end else if (rsp.ready) begin
                  rsp.valid <= 1'b0;
                  if (i_ff + 1'b1 == cnt_ff) begin
                     cnt_ff <= '0; st_ff <= S_LOAD;
                  end else begin
                     i_ff <= i_ff + 1'b1; st_ff <= S_EMIT;
                  end
               end
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end
endmodule

@@ sv/sfc_checker.sv @@
// Port-level checker for the curve sort, bound to the top level.
module sfc_port_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_run_end
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_run_end)) else $error("run_end moved");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid) else $error("no gap after result");
endmodule

bind space_filling_curve_sort sfc_port_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_run_end(rsp.run_end)
);
